FILE: src/ssc_pkg.sv
// Shared types and constants for the stroke stamp compositor.
package ssc_pkg;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_STAMP = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HEIGHT_STEP  = 2'd2;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [11:0] RST_HEIGHT_STEP  = 12'd4;

  localparam logic [8:0]  COV_FULL   = 9'd256;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [23:0] HEIGHT_MAX = 24'hFFFFFF;

  // height numerator and quotient after division by 255
  localparam int NUM_W  = 33;
  localparam int QUOT_W = 26;

  typedef struct packed {
    logic [15:0] mark;
    logic [23:0] saved;
    logic [8:0]  best;
    logic [23:0] canvas;
    logic [23:0] height;
  } pix_t;

endpackage

FILE: src/stroke_stamp_composite.sv
// Top level: brush stroke compositor over a per-pixel canvas memory.
//
// Items enter on the in channel (in_valid/in_stall) and one result per item
// leaves on the out channel (out_valid/out_stall). Transfers happen when valid
// is high and stall is low. Commands: init pixel, begin stroke, stamp sample,
// read pixel. All pixel state lives in one memory of MAX_WIDTH*MAX_HEIGHT
// words with a registered read.
// The pixel word is read on the input transfer edge; blend and height products,
// two stages of the divide by 255, then write-back into the memory together
// with the output register follow. One item is in flight at a time, so a new
// item is taken only once the last one has been written back; the read-modify-write
// of the pixel word requires this.
// A result waiting in the output register does not block the next input
// transfer; only the write-back of the next item waits on it.
// Reset clears the stroke counter, stroke colour and control state and loads
// the config register defaults. The pixel memory is not cleared: pixels must
// be initialized before a stamp or read. Config writes via
// cfg_we/cfg_index/cfg_data must only be made while no item is in flight.
module stroke_stamp_composite import ssc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [10:0] pos_x,
  input  logic [10:0] pos_y,
  input  logic [7:0]  colour_r,
  input  logic [7:0]  colour_g,
  input  logic [7:0]  colour_b,
  input  logic [8:0]  coverage,
  input  logic [7:0]  tex_height,
  input  logic [7:0]  tex_opacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        written,
  output logic [7:0]  out_r,
  output logic [7:0]  out_g,
  output logic [7:0]  out_b,
  output logic [23:0] out_height
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(NPIX);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_DV1  = 5'b00100,
    S_DV2  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  function automatic logic [7:0] blend_chan(input logic [7:0] fg, input logic [7:0] bg,
                                            input logic [8:0] a);
    logic signed [9:0]  d;
    logic signed [10:0] as;
    logic signed [20:0] p;
    logic signed [20:0] s;
    d  = signed'({2'b00, fg}) - signed'({2'b00, bg});
    as = signed'({2'b00, a});
    p  = d * as;
    s  = signed'({5'b00000, bg, 8'h00}) + p + 21'sd128;
    return s[15:8];
  endfunction

  state_t state;

  logic [8:0]  image_width;
  logic [8:0]  image_height;
  logic [11:0] height_step;
  logic [15:0] stroke_count;
  logic [23:0] stroke_rgb;

  // item registers
  cmd_t        it_cmd;
  logic        it_on;
  logic [23:0] it_rgb;
  logic [8:0]  it_cov;
  logic [7:0]  it_sh;
  logic [7:0]  it_op;
  logic [AW-1:0] it_addr;

  pix_t        mem [NPIX];
  pix_t        rd_data;

  // products of the read stage
  logic        st_first;
  logic        st_win;
  logic [23:0] saved_new;
  logic [23:0] rgb_new;
  logic [15:0] hprod_a;
  logic [31:0] hprod_b;
  logic [27:0] stepcnt;

  logic [NUM_W-1:0]  num;
  logic [QUOT_W-1:0] quot;

  logic        in_xfer;
  logic        x_ok;
  logic        y_ok;
  logic [AW-1:0] idx;
  logic [8:0]  cov_sat;

  logic        fin_go;
  logic        mem_we;
  pix_t        wr_data;
  logic        res_written;
  logic [23:0] res_rgb;
  logic [23:0] res_height;
  logic [28:0] hsum;
  logic [23:0] hnew;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    x_ok = !pos_x[10] && (32'(pos_x[9:0]) < 32'(image_width))
           && (32'(pos_x[9:0]) < 32'(MAX_WIDTH));
    y_ok = !pos_y[10] && (32'(pos_y[9:0]) < 32'(image_height))
           && (32'(pos_y[9:0]) < 32'(MAX_HEIGHT));
    idx  = AW'(32'(pos_y[9:0]) * 32'(MAX_WIDTH) + 32'(pos_x[9:0]));
    cov_sat = (coverage > COV_FULL) ? COV_FULL : coverage;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      height_step  <= RST_HEIGHT_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[8:0];
        REG_HEIGHT_STEP:  height_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_cmd  <= cmd_t'(cmd);
      it_on   <= x_ok && y_ok;
      it_rgb  <= {colour_r, colour_g, colour_b};
      it_cov  <= cov_sat;
      it_sh   <= tex_height;
      it_op   <= tex_opacity;
      it_addr <= idx;
    end
  end

  // pixel memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[it_addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_data <= mem[idx];
    end
  end

  // read stage: stroke decisions, colour blend and height products
  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      st_first  <= (rd_data.mark < stroke_count);
      st_win    <= (rd_data.best < it_cov);
      saved_new <= (rd_data.mark < stroke_count) ? rd_data.canvas : rd_data.saved;
      rgb_new   <= (rd_data.mark < stroke_count)
                   ? {blend_chan(stroke_rgb[23:16], rd_data.canvas[23:16], it_cov),
                      blend_chan(stroke_rgb[15:8],  rd_data.canvas[15:8],  it_cov),
                      blend_chan(stroke_rgb[7:0],   rd_data.canvas[7:0],   it_cov)}
                   : {blend_chan(stroke_rgb[23:16], rd_data.saved[23:16], it_cov),
                      blend_chan(stroke_rgb[15:8],  rd_data.saved[15:8],  it_cov),
                      blend_chan(stroke_rgb[7:0],   rd_data.saved[7:0],   it_cov)};
      hprod_a   <= it_sh * it_op;
      hprod_b   <= rd_data.height * (8'd255 - it_op);
      stepcnt   <= height_step * stroke_count;
    end
  end

  assign num = NUM_W'({hprod_a, 12'h000}) + NUM_W'(hprod_b) + NUM_W'(127);

  ssc_div255 u_div (
    .clk  (clk),
    .num  (num),
    .quot (quot)
  );

  always_comb begin
    hsum = 29'(quot) + 29'(stepcnt);
    hnew = (hsum > 29'(HEIGHT_MAX)) ? HEIGHT_MAX : hsum[23:0];
  end

  // write-back and result selection
  always_comb begin
    fin_go      = (state == S_FIN) && (!out_valid || !out_stall);
    wr_data     = rd_data;
    mem_we      = 1'b0;
    res_written = 1'b0;
    res_rgb     = 24'h000000;
    res_height  = 24'h000000;
    if (it_on) begin
      case (it_cmd)
        CMD_INIT: begin
          wr_data.canvas = it_rgb;
          wr_data.height = 24'h000000;
          wr_data.mark   = 16'h0000;
          mem_we         = fin_go;
          res_written    = 1'b1;
          res_rgb        = it_rgb;
        end
        CMD_STAMP: begin
          if (st_first || st_win) begin
            wr_data.mark   = st_first ? stroke_count : rd_data.mark;
            wr_data.saved  = saved_new;
            wr_data.best   = it_cov;
            wr_data.canvas = rgb_new;
            wr_data.height = hnew;
            mem_we         = fin_go;
            res_written    = 1'b1;
            res_rgb        = rgb_new;
            res_height     = hnew;
          end else begin
            res_rgb    = rd_data.canvas;
            res_height = rd_data.height;
          end
        end
        CMD_READ: begin
          res_rgb    = rd_data.canvas;
          res_height = rd_data.height;
        end
        default: ;
      endcase
    end
  end

  // sequencer, stroke state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      stroke_count <= 16'h0000;
      stroke_rgb   <= 24'h000000;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_xfer) state <= S_RD;
        S_RD:   state <= S_DV1;
        S_DV1:  state <= S_DV2;
        S_DV2:  state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
            if (it_cmd == CMD_BEGIN) begin
              if (stroke_count != COUNT_MAX) begin
                stroke_count <= stroke_count + 16'd1;
              end
              stroke_rgb <= it_rgb;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      written    <= res_written;
      out_r      <= res_rgb[23:16];
      out_g      <= res_rgb[15:8];
      out_b      <= res_rgb[7:0];
      out_height <= res_height;
    end
  end

endmodule

FILE: src/ssc_div255.sv
// Two-stage pipelined divider by the constant 255 for the height numerator.
module ssc_div255 import ssc_pkg::*; (
  input  logic              clk,
  input  logic [NUM_W-1:0]  num,
  output logic [QUOT_W-1:0] quot
);

  localparam logic [8:0] DIV_K = 9'd255;

  // x = 256q + l = 255q + (q + l): fold the high part down until the rest is small
  logic [24:0] q1;
  logic [25:0] r1;
  logic [17:0] q2;
  logic [18:0] r2;
  logic [25:0] qa;
  logic [18:0] rr;
  logic [10:0] q3;
  logic [11:0] r3;
  logic [3:0]  q4;
  logic [8:0]  r4;
  logic        corr;

  always_comb begin
    q1 = num[32:8];
    r1 = 26'(num[7:0]) + 26'(q1);
    q2 = r1[25:8];
    r2 = 19'(r1[7:0]) + 19'(q2);
  end

  always_ff @(posedge clk) begin
    qa <= 26'(q1) + 26'(q2);
    rr <= r2;
  end

  always_comb begin
    q3   = rr[18:8];
    r3   = 12'(rr[7:0]) + 12'(q3);
    q4   = r3[11:8];
    r4   = 9'(r3[7:0]) + 9'(q4);
    corr = (r4 >= DIV_K);
  end

  always_ff @(posedge clk) begin
    quot <= qa + 26'(q3) + 26'(q4) + 26'(corr);
  end

endmodule

FILE: test/stroke_stamp_checker.sv
// Checker for the stroke stamp compositor: predicts each pixel result and compares.
module stroke_stamp_checker
  import ssc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [10:0] pos_x,
  input  logic [10:0] pos_y,
  input  logic [7:0]  colour_r,
  input  logic [7:0]  colour_g,
  input  logic [7:0]  colour_b,
  input  logic [8:0]  coverage,
  input  logic [7:0]  tex_height,
  input  logic [7:0]  tex_opacity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        written,
  input  logic [7:0]  out_r,
  input  logic [7:0]  out_g,
  input  logic [7:0]  out_b,
  input  logic [23:0] out_height,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic        wr;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [23:0] h;
  } pixel_out_t;

  logic [8:0]  width_q;
  logic [8:0]  height_q;
  logic [11:0] step_q;
  logic [15:0] strokes;
  logic [23:0] brush_rgb;

  logic [15:0] mark_mem   [NPIX];
  logic [23:0] saved_mem  [NPIX];
  logic [8:0]  best_mem   [NPIX];
  logic [23:0] canvas_mem [NPIX];
  logic [23:0] height_mem [NPIX];

  pixel_out_t pixel_results_due [$];
  int errors = 0;

  function automatic logic [7:0] mix_chan(logic [7:0] fg, logic [7:0] bg, logic [8:0] a);
    logic [16:0] acc;
    acc = fg * a + bg * (9'd256 - a) + 17'd128;
    return acc[15:8];
  endfunction

  function automatic logic [23:0] mix_rgb(logic [23:0] fg, logic [23:0] bg, logic [8:0] a);
    return {mix_chan(fg[23:16], bg[23:16], a), mix_chan(fg[15:8], bg[15:8], a),
            mix_chan(fg[7:0], bg[7:0], a)};
  endfunction

  // opacity blend toward the stroke height, plus the per-stroke lift, saturating
  function automatic logic [23:0] paint_height(logic [7:0] sh, logic [7:0] op,
                                               logic [23:0] cur);
    logic [39:0] num;
    num = 40'(sh) * 40'd4096 * 40'(op) + 40'(cur) * 40'(8'd255 - op) + 40'd127;
    num = num / 40'd255 + 40'(step_q) * 40'(strokes);
    return (num > 40'(HEIGHT_MAX)) ? HEIGHT_MAX : num[23:0];
  endfunction

  function automatic pixel_out_t composite_pixel(cmd_t c, logic [10:0] px, logic [10:0] py,
                                                 logic [23:0] rgb, logic [8:0] cov_in,
                                                 logic [7:0] sh, logic [7:0] op);
    pixel_out_t res;
    int sx, sy, lim_w, lim_h, i;
    logic [8:0] cov;
    logic win;
    res = '0;
    win = 1'b0;
    cov = (cov_in > COV_FULL) ? COV_FULL : cov_in;
    if (c == CMD_BEGIN) begin
      if (strokes != COUNT_MAX) strokes = strokes + 16'd1;
      brush_rgb = rgb;
      return res;
    end
    sx = $signed(px);
    sy = $signed(py);
    lim_w = (int'(width_q) < MAX_WIDTH) ? int'(width_q) : MAX_WIDTH;
    lim_h = (int'(height_q) < MAX_HEIGHT) ? int'(height_q) : MAX_HEIGHT;
    if (sx < 0 || sy < 0 || sx >= lim_w || sy >= lim_h) return res;
    i = sy * MAX_WIDTH + sx;
    case (c)
      CMD_INIT: begin
        canvas_mem[i] = rgb;
        height_mem[i] = '0;
        mark_mem[i]   = '0;
        win = 1'b1;
      end
      CMD_STAMP: begin
        if (mark_mem[i] < strokes) begin
          // first touch by this stroke: keep the colour underneath
          mark_mem[i]  = strokes;
          saved_mem[i] = canvas_mem[i];
          win = 1'b1;
        end else if (best_mem[i] < cov) begin
          win = 1'b1;
        end
        if (win) begin
          best_mem[i]   = cov;
          canvas_mem[i] = mix_rgb(brush_rgb, saved_mem[i], cov);
          height_mem[i] = paint_height(sh, op, height_mem[i]);
        end
      end
      default: ;
    endcase
    res.wr = win;
    res.r  = canvas_mem[i][23:16];
    res.g  = canvas_mem[i][15:8];
    res.b  = canvas_mem[i][7:0];
    res.h  = height_mem[i];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_out_t got;
    pixel_out_t want;
    pixel_out_t due;
    if (rst) begin
      width_q   = RST_IMAGE_WIDTH;
      height_q  = RST_IMAGE_HEIGHT;
      step_q    = RST_HEIGHT_STEP;
      strokes   = '0;
      brush_rgb = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_q  = cfg_data[8:0];
          REG_IMAGE_HEIGHT: height_q = cfg_data[8:0];
          REG_HEIGHT_STEP:  step_q   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due = composite_pixel(cmd_t'(cmd), pos_x, pos_y,
            {colour_r, colour_g, colour_b}, coverage, tex_height, tex_opacity);
        pixel_results_due = {pixel_results_due, due};
      end
      if (out_valid && !out_stall) begin
        got = {written, out_r, out_g, out_b, out_height};
        if (pixel_results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with nothing expected: wr=%0d rgb=%02h%02h%02h h=%06h",
                     $realtime, got.wr, got.r, got.g, got.b, got.h);
        end else begin
          want = pixel_results_due.pop_front();
          if (got.wr !== want.wr || got.r !== want.r || got.g !== want.g ||
              got.b !== want.b || got.h !== want.h) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp wr=%0d rgb=%02h%02h%02h h=%06h",
                       $realtime, want.wr, want.r, want.g, want.b, want.h);
              $display("%0t:          got wr=%0d rgb=%02h%02h%02h h=%06h",
                       $realtime, got.wr, got.r, got.g, got.b, got.h);
            end
          end
        end
      end
    end
    pending    <= pixel_results_due.size();
    fail_count <= errors;
  end

endmodule

FILE: test/stroke_stamp_composite_tb.sv
// Top of the stroke stamp compositor testbench: clock, reset, stimulus and verdict.
module stroke_stamp_composite_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssc_pkg::*;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int N_PH = 9;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_INIT;
  logic [10:0] pos_x = '0;
  logic [10:0] pos_y = '0;
  logic [7:0]  colour_r = '0;
  logic [7:0]  colour_g = '0;
  logic [7:0]  colour_b = '0;
  logic [8:0]  coverage = '0;
  logic [7:0]  tex_height = '0;
  logic [7:0]  tex_opacity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        written;
  logic [7:0]  out_r;
  logic [7:0]  out_g;
  logic [7:0]  out_b;
  logic [23:0] out_height;
  int          pending;
  int          fail_count;

  idle_mode_t idle_mode = IDLE_NONE;
  int cur_w = RST_IMAGE_WIDTH;
  int cur_h = RST_IMAGE_HEIGHT;
  bit began = 1'b0;
  bit inited [DEF_MAX_WIDTH * DEF_MAX_HEIGHT];

  int         ph_w     [N_PH] = '{256, 16, 1, 300, 0, 200, 256, 256, 5};
  int         ph_h     [N_PH] = '{256, 8, 1, 511, 200, 0, 256, 256, 3};
  int         ph_step  [N_PH] = '{4095, 0, 1, 2048, 7, 9, 4, 300, 1};
  idle_mode_t ph_mode  [N_PH] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
                                  IDLE_SEND, IDLE_RECV, IDLE_NONE, IDLE_BOTH};
  int         ph_items [N_PH] = '{60, 60, 50, 60, 10, 10, 60, 40, 50};

  stroke_stamp_composite u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
    .colour_r(colour_r), .colour_g(colour_g), .colour_b(colour_b),
    .coverage(coverage), .tex_height(tex_height), .tex_opacity(tex_opacity),
    .out_valid(out_valid), .out_stall(out_stall),
    .written(written), .out_r(out_r), .out_g(out_g), .out_b(out_b),
    .out_height(out_height)
  );

  stroke_stamp_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
    .colour_r(colour_r), .colour_g(colour_g), .colour_b(colour_b),
    .coverage(coverage), .tex_height(tex_height), .tex_opacity(tex_opacity),
    .out_valid(out_valid), .out_stall(out_stall),
    .written(written), .out_r(out_r), .out_g(out_g), .out_b(out_b),
    .out_height(out_height),
    .pending(pending), .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_stall <= ($urandom_range(0, 99) < 59);
      IDLE_BOTH: out_stall <= ($urandom_range(0, 99) < 9);
      default:   out_stall <= 1'b0;
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_cov();
    case ($urandom_range(0, 7))
      0:       return 9'd0;
      1:       return COV_FULL;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic sender_gap();
    case (idle_mode)
      IDLE_SEND:
        while ($urandom_range(0, 99) < 59) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      IDLE_BOTH:
        while ($urandom_range(0, 99) < 9) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      default: ;
    endcase
  endtask

  // returns at the edge where the transfer happened; valid is left high
  task automatic issue(cmd_t c, logic [10:0] x, logic [10:0] y, logic [23:0] rgb,
                       logic [8:0] cov, logic [7:0] sh, logic [7:0] op);
    int sx, sy, ew, eh, i;
    bit on;
    sx = $signed(x);
    sy = $signed(y);
    ew = (cur_w < DEF_MAX_WIDTH) ? cur_w : DEF_MAX_WIDTH;
    eh = (cur_h < DEF_MAX_HEIGHT) ? cur_h : DEF_MAX_HEIGHT;
    on = (sx >= 0 && sy >= 0 && sx < ew && sy < eh);
    i = on ? sy * DEF_MAX_WIDTH + sx : 0;
    // never touch a pixel store entry before it holds data
    if (on && (c == CMD_STAMP || c == CMD_READ) && !inited[i]) c = CMD_INIT;
    if (on && c == CMD_STAMP && !began) c = CMD_INIT;
    if (c == CMD_BEGIN) began = 1'b1;
    if (on && c == CMD_INIT) inited[i] = 1'b1;
    sender_gap();
    in_valid    <= 1'b1;
    cmd         <= c;
    pos_x       <= x;
    pos_y       <= y;
    colour_r    <= rgb[23:16];
    colour_g    <= rgb[15:8];
    colour_b    <= rgb[7:0];
    coverage    <= cov;
    tex_height  <= sh;
    tex_opacity <= op;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_config(int w, int h, int step);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= 12'(w);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= 12'(h);
    @(posedge clk);
    cfg_index <= REG_HEIGHT_STEP;
    cfg_data  <= 12'(step);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w & 511;
    cur_h = h & 511;
  endtask

  task automatic random_item();
    int ew, eh, k, span_x, span_y;
    logic [10:0] x, y;
    cmd_t c;
    ew = (cur_w < DEF_MAX_WIDTH) ? cur_w : DEF_MAX_WIDTH;
    eh = (cur_h < DEF_MAX_HEIGHT) ? cur_h : DEF_MAX_HEIGHT;
    k = $urandom_range(0, 99);
    x = 11'($urandom);
    y = 11'($urandom);
    if (k < 5) begin
      c = CMD_BEGIN;
    end else if (k < 13 || ew == 0 || eh == 0) begin
      c = cmd_t'($urandom_range(0, 3));
    end else begin
      // mostly a small patch so that strokes revisit pixels
      span_x = ($urandom_range(0, 99) < 80 && ew > 8) ? 8 : ew;
      span_y = ($urandom_range(0, 99) < 80 && eh > 8) ? 8 : eh;
      x = 11'($urandom_range(0, span_x - 1));
      y = 11'($urandom_range(0, span_y - 1));
      c = (k < 25) ? CMD_INIT : (k < 88) ? CMD_STAMP : CMD_READ;
    end
    issue(c, x, y, {pick_byte(), pick_byte(), pick_byte()}, pick_cov(),
          pick_byte(), pick_byte());
  endtask

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    load_config(256, 256, 4);

    issue(CMD_BEGIN, 0, 0, 24'hFF00FF, 0, 0, 0);
    issue(CMD_INIT, 0, 0, 24'h00FF00, 0, 0, 0);
    issue(CMD_INIT, 255, 255, 24'hFFFFFF, 0, 0, 0);
    issue(CMD_INIT, 11'h7FF, 0, 24'h123456, 0, 0, 0);
    issue(CMD_INIT, 256, 5, 24'h654321, 0, 0, 0);
    issue(CMD_INIT, 3, 256, 24'hABCDEF, 0, 0, 0);
    issue(CMD_READ, 0, 0, 0, 0, 0, 0);
    issue(CMD_STAMP, 0, 0, 0, 9'd128, 8'd255, 8'd255);
    issue(CMD_STAMP, 0, 0, 0, 9'd64, 8'd10, 8'd20);
    issue(CMD_STAMP, 0, 0, 0, 9'h1FF, 8'd255, 8'd0);
    issue(CMD_STAMP, 0, 0, 0, COV_FULL, 8'd0, 8'd255);
    issue(CMD_STAMP, 255, 255, 0, 9'd0, 8'd0, 8'd0);
    issue(CMD_STAMP, 255, 255, 0, 9'd1, 8'd255, 8'd128);
    issue(CMD_STAMP, 11'h400, 11'h400, 0, 9'd100, 8'd1, 8'd1);
    issue(CMD_STAMP, 11'h3FF, 11'h3FF, 0, 9'd100, 8'd1, 8'd1);
    issue(CMD_READ, 255, 255, 0, 0, 0, 0);
    issue(CMD_READ, 0, 11'h7FF, 0, 0, 0, 0);
    issue(CMD_BEGIN, 0, 0, 24'h000000, 0, 0, 0);
    issue(CMD_STAMP, 0, 0, 0, 9'd200, 8'd255, 8'd128);
    issue(CMD_INIT, 0, 0, 24'h808080, 0, 0, 0);
    issue(CMD_STAMP, 0, 0, 0, COV_FULL, 8'd128, 8'd255);
    issue(CMD_BEGIN, 11'h7FF, 11'h7FF, 24'hFFFFFF, 9'h1FF, 8'hFF, 8'hFF);
    issue(CMD_STAMP, 255, 255, 0, 9'd255, 8'd255, 8'd255);
    issue(CMD_READ, 11'h100, 0, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < N_PH; p++) begin
      load_config(ph_w[p], ph_h[p], ph_step[p]);
      idle_mode <= ph_mode[p];
      repeat (ph_items[p]) begin
        random_item();
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: stroke_stamp_composite.f
src/ssc_pkg.sv
src/ssc_div255.sv
src/stroke_stamp_composite.sv
test/stroke_stamp_checker.sv
test/stroke_stamp_composite_tb.sv
